FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file sarc_checker.sv
// no dependencies; each macro expands to one concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define SARC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is asserted
`define SARC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sarc_pkg.sv
// types, codes and constants of the serial adc read controller
// no dependencies; used by every other file of the block but assert_macros.svh
package sarc_pkg;

	localparam int DATA_BITS_DEF = 8;
	localparam int VALUE_W       = 8;
	localparam int HALF_W        = 8;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 8;

	localparam logic              MODE_RST = 1'b1;
	localparam logic [HALF_W-1:0] HALF_RST = 8'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SINGLE_ENDED = 1'b0,
		CFG_HALF_PERIOD  = 1'b1
	} cfg_idx_t;

	// while running, odd phases hold the clock low, even phases high
	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_START_LOW  = 4'd1,
		PH_START_HIGH = 4'd2,
		PH_MODE_LOW   = 4'd3,
		PH_MODE_HIGH  = 4'd4,
		PH_CHAN_LOW   = 4'd5,
		PH_CHAN_HIGH  = 4'd6,
		PH_RELEASE    = 4'd7,
		PH_MSB_HIGH   = 4'd8,
		PH_MSB_LOW    = 4'd9,
		PH_LSB_HIGH   = 4'd10,
		PH_LSB_LOW    = 4'd11,
		PH_DONE       = 4'd12
	} phase_t;

	typedef struct packed {
		logic start_request;
		logic channel;
		logic dio_in;
	} in_item_t;

	typedef struct packed {
		logic               chip_select_n;
		logic               serial_clock;
		logic               dio_out;
		logic               busy_res;
		logic               done_res;
		logic [VALUE_W-1:0] value;
		logic               readings_match;
	} out_item_t;

endpackage

FILE: rtl/core/sarc_if.sv
// valid/ready channel interfaces for tick items and result items
// depends on sarc_pkg for the value width
interface sarc_in_if;
	logic valid;
	logic ready;
	logic start_request;
	logic channel;
	logic dio_in;

	modport source (output valid, output start_request, output channel, output dio_in,
		input ready);
	modport sink (input valid, input start_request, input channel, input dio_in,
		output ready);
endinterface

interface sarc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         chip_select_n;
	logic                         serial_clock;
	logic                         dio_out;
	logic                         busy_res;
	logic                         done_res;
	logic [sarc_pkg::VALUE_W-1:0] value;
	logic                         readings_match;

	modport source (output valid, output chip_select_n, output serial_clock,
		output dio_out, output busy_res, output done_res, output value,
		output readings_match, input ready);
	modport sink (input valid, input chip_select_n, input serial_clock,
		input dio_out, input busy_res, input done_res, input value,
		input readings_match, output ready);
endinterface

FILE: rtl/core/serial_adc_read_controller_top.sv
// top level of the serial adc read controller
// depends on sarc_pkg, sarc_if, sarc_in_stage, sarc_seq and sarc_out_reg
//
// Tick-stepped master for a two-channel 8-bit serial converter. Every transfer on
// in_ch is one tick of the pin sequencer and yields exactly one transfer on out_ch
// carrying the chip select, clock and data drive levels for that tick, plus busy,
// done and, on the done tick, the value and the match flag. A start request while
// idle lowers chip select, sends start, mode and channel bits, then reads the
// result msb first and lsb first; value is 0 when the two readings differ.
// One tick is accepted every clock cycle unless the result channel stalls. Ticks
// pass the input register, the sequencer step, then the result register; the
// input register can take a new tick while the previous result waits. The user
// writes configuration (cfg_we, cfg_index, cfg_data) between sequences; the
// block does not enforce it. Index 0 is the single-ended mode bit, index 1 the
// half clock period in ticks (0 counts as 1).
module serial_adc_read_controller_top #(
	parameter int DATA_BITS = sarc_pkg::DATA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sarc_in_if.sink                         in_ch,
	sarc_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [sarc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sarc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic                        mode_q;
	logic [sarc_pkg::HALF_W-1:0] half_q;

	// stage one: the accepted tick waiting for the sequencer
	logic                valid_s1;
	sarc_pkg::in_item_t  item_s1;

	// sequencer step and result register handshake
	sarc_pkg::out_item_t result;
	logic                can_load;
	logic                advance;

	// a tick steps the sequencer once the result register has room
	assign advance = valid_s1 && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sarc_pkg::MODE_RST;
			half_q <= sarc_pkg::HALF_RST;
		end else if (cfg_we) begin
			case (sarc_pkg::cfg_idx_t'(cfg_index))
				sarc_pkg::CFG_SINGLE_ENDED: mode_q <= cfg_data[0];
				sarc_pkg::CFG_HALF_PERIOD:  half_q <= cfg_data[sarc_pkg::HALF_W-1:0];
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	// input register
	sarc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// phase sequencer, divider and both shift registers
	sarc_seq #(
		.DATA_BITS (DATA_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.item         (item_s1),
		.single_ended (mode_q),
		.half_ticks   (half_q),
		.result       (result)
	);

	// result register, one transfer per tick
	sarc_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.result   (result),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

endmodule

FILE: rtl/core/sarc_in_stage.sv
// input register of the controller: holds one accepted tick item
// depends on sarc_pkg and sarc_in_if
module sarc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	sarc_in_if.sink             in_ch,
	input  logic                advance,
	output logic                valid_s1,
	output sarc_pkg::in_item_t  item_s1
);

	logic take;

	assign in_ch.ready = !valid_s1 || advance;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.start_request <= in_ch.start_request;
			item_s1.channel       <= in_ch.channel;
			item_s1.dio_in        <= in_ch.dio_in;
		end
	end

endmodule

FILE: rtl/core/sarc_seq.sv
// pin sequencer of the controller: phase, divider and shift state, one tick per enable
// depends on sarc_pkg
module sarc_seq #(
	parameter int DATA_BITS = sarc_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  sarc_pkg::in_item_t          item,
	input  logic                        single_ended,
	input  logic [sarc_pkg::HALF_W-1:0] half_ticks,
	output sarc_pkg::out_item_t         result
);

	localparam int CNT_W = $clog2(DATA_BITS + 1);
	localparam int EXT_W = (DATA_BITS > sarc_pkg::VALUE_W) ? DATA_BITS : sarc_pkg::VALUE_W;

	sarc_pkg::phase_t            ph_q, ph_eff, ph_n;
	logic [sarc_pkg::HALF_W-1:0] div_q, div_eff, div_n, div_inc, half_eff;
	logic [CNT_W-1:0]            cnt_q, cnt_eff, cnt_n, cnt_inc;
	logic [CNT_W:0]              lsb_pos;
	logic [DATA_BITS-1:0]        msb_q, msb_eff, msb_n;
	logic [DATA_BITS-1:0]        lsb_q, lsb_eff, lsb_n;
	logic                        chan_q, chan_eff;
	logic                        start_go, running, phase_end, match;
	logic [EXT_W-1:0]            msb_ext;

	// start while idle: the same tick already runs the first low phase
	always_comb begin
		start_go = (ph_q == sarc_pkg::PH_IDLE) && item.start_request;
		ph_eff   = start_go ? sarc_pkg::PH_START_LOW : ph_q;
		chan_eff = start_go ? item.channel : chan_q;
		div_eff  = start_go ? '0 : div_q;
		cnt_eff  = start_go ? '0 : cnt_q;
		msb_eff  = start_go ? '0 : msb_q;
		lsb_eff  = start_go ? '0 : lsb_q;
		running  = (ph_eff != sarc_pkg::PH_IDLE) && (ph_eff != sarc_pkg::PH_DONE);
		half_eff = (half_ticks == '0) ? sarc_pkg::HALF_W'(1) : half_ticks;
		div_inc  = div_eff + sarc_pkg::HALF_W'(1);
		phase_end = running && (div_inc >= half_eff);
		cnt_inc  = cnt_eff + CNT_W'(1);
		lsb_pos  = {1'b0, cnt_eff} + (CNT_W+1)'(1);
		match    = (msb_eff == lsb_eff);
		msb_ext  = EXT_W'(msb_eff);
	end

	// next state
	always_comb begin
		ph_n  = ph_eff;
		div_n = div_eff;
		cnt_n = cnt_eff;
		msb_n = msb_eff;
		lsb_n = lsb_eff;
		if (running) begin
			div_n = phase_end ? '0 : div_inc;
		end else begin
			ph_n  = sarc_pkg::PH_IDLE;
			div_n = (ph_eff == sarc_pkg::PH_DONE) ? '0 : div_eff;
		end
		if (phase_end) begin
			case (ph_eff)
				sarc_pkg::PH_MSB_LOW: begin
					msb_n = (msb_eff << 1) | DATA_BITS'(item.dio_in);
					if (cnt_inc >= CNT_W'(DATA_BITS)) begin
						// converter shares the last msb-first bit as lsb-first bit zero
						lsb_n = DATA_BITS'(item.dio_in);
						cnt_n = '0;
						ph_n  = sarc_pkg::PH_LSB_HIGH;
					end else begin
						cnt_n = cnt_inc;
						ph_n  = sarc_pkg::PH_MSB_HIGH;
					end
				end
				sarc_pkg::PH_LSB_LOW: begin
					for (int i = 0; i < DATA_BITS; i++) begin
						if (lsb_pos == (CNT_W+1)'(i)) begin
							lsb_n[i] = lsb_eff[i] | item.dio_in;
						end
					end
					cnt_n = cnt_inc;
					ph_n  = (cnt_inc >= CNT_W'(DATA_BITS)) ? sarc_pkg::PH_DONE
						: sarc_pkg::PH_LSB_HIGH;
				end
				default: begin
					ph_n = sarc_pkg::phase_t'(ph_eff + 4'd1);
				end
			endcase
		end
	end

	// pin levels and result of this tick
	always_comb begin
		result                = '0;
		result.chip_select_n  = 1'b1;
		result.dio_out        = 1'b1;
		case (ph_eff)
			sarc_pkg::PH_IDLE: begin
				result.chip_select_n = 1'b1;
			end
			sarc_pkg::PH_DONE: begin
				result.done_res       = 1'b1;
				result.readings_match = match;
				result.value          = match ? msb_ext[sarc_pkg::VALUE_W-1:0] : '0;
			end
			sarc_pkg::PH_MODE_LOW, sarc_pkg::PH_MODE_HIGH: begin
				result.dio_out = single_ended;
			end
			sarc_pkg::PH_CHAN_LOW, sarc_pkg::PH_CHAN_HIGH: begin
				result.dio_out = chan_eff;
			end
			default: begin
				result.dio_out = 1'b1;
			end
		endcase
		if (running) begin
			result.chip_select_n = 1'b0;
			result.busy_res      = 1'b1;
			result.serial_clock  = ~ph_eff[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= sarc_pkg::PH_IDLE;
			div_q  <= '0;
			cnt_q  <= '0;
			msb_q  <= '0;
			lsb_q  <= '0;
			chan_q <= 1'b0;
		end else if (en) begin
			ph_q   <= ph_n;
			div_q  <= div_n;
			cnt_q  <= cnt_n;
			msb_q  <= msb_n;
			lsb_q  <= lsb_n;
			chan_q <= chan_eff;
		end
	end

endmodule

FILE: rtl/core/sarc_out_reg.sv
// result register of the controller, drives the result channel
// depends on sarc_pkg and sarc_out_if
module sarc_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sarc_pkg::out_item_t result,
	output logic                can_load,
	sarc_out_if.source          out_ch
);

	logic               valid_q;
	sarc_pkg::out_item_t res_q;

	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign out_ch.valid          = valid_q;
	assign out_ch.chip_select_n  = res_q.chip_select_n;
	assign out_ch.serial_clock   = res_q.serial_clock;
	assign out_ch.dio_out        = res_q.dio_out;
	assign out_ch.busy_res       = res_q.busy_res;
	assign out_ch.done_res       = res_q.done_res;
	assign out_ch.value          = res_q.value;
	assign out_ch.readings_match = res_q.readings_match;

endmodule

FILE: rtl/core/sarc_checker.sv
// port-level checks of the serial adc read controller, bound to the top level
// depends on sarc_pkg and assert_macros.svh
`include "assert_macros.svh"

module sarc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         out_cs_n,
	input logic                         out_sclk,
	input logic                         out_dio,
	input logic                         out_busy,
	input logic                         out_done,
	input logic [sarc_pkg::VALUE_W-1:0] out_value,
	input logic                         out_match
);

	// a stalled result holds
	`SARC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_done) && $stable(out_busy), "stalled result changed")

	// value and match flag only on the done tick
	`SARC_ASSERT_IMPLY(a_res_done_only, clk, arst_n, out_valid && !out_done, out_value == '0 && !out_match, "result outside done tick")

	// a mismatch reports zero
	`SARC_ASSERT_IMPLY(a_mismatch_zero, clk, arst_n, out_valid && !out_match, out_value == '0, "nonzero value without match")

	// chip select low exactly while busy, pins parked otherwise
	`SARC_ASSERT_IMPLY(a_idle_pins, clk, arst_n, out_valid && !out_busy, out_cs_n && !out_sclk && out_dio, "pins not parked while not busy")

	`SARC_ASSERT_IMPLY(a_busy_cs, clk, arst_n, out_valid && out_busy, !out_cs_n && !out_done, "chip select high while busy")

endmodule

bind serial_adc_read_controller_top sarc_checker u_sarc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_cs_n  (out_ch.chip_select_n),
	.out_sclk  (out_ch.serial_clock),
	.out_dio   (out_ch.dio_out),
	.out_busy  (out_ch.busy_res),
	.out_done  (out_ch.done_res),
	.out_value (out_ch.value),
	.out_match (out_ch.readings_match)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for serial_adc_read_controller_top
// depends on sarc_pkg and the sarc_in_if / sarc_out_if channel interfaces
module testbench;
	import sarc_pkg::*;

	localparam int DBITS       = DATA_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sarc_in_if  in_ch ();
	sarc_out_if out_ch ();

	serial_adc_read_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// sequencer shadow: configuration and state of the pin sequencer
	logic              sel_mode;
	logic [HALF_W-1:0] half_ticks;
	phase_t            ph;
	logic [7:0]        tick_div;
	logic [DBITS-1:0]  msb_word;
	logic [DBITS-1:0]  lsb_word;
	int                bits_in;
	logic              chan_latch;

	// converter model driving the data line during the read-back
	logic [DBITS-1:0] adc_sample;
	logic [DBITS-1:0] lsb_flip;
	logic             noisy_line;

	out_item_t pending_pins[$];
	out_item_t want_pins;
	int        mismatches;
	int        ticks_sent;
	int        cycle_count;
	int        send_idle_pct;
	int        recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pin levels and result for one accepted tick; advances the shadow state
	function automatic out_item_t pins_for_tick(in_item_t tick);
		out_item_t  r;
		logic [7:0] eff_half;
		eff_half = (half_ticks == '0) ? 8'd1 : half_ticks;
		r = '0;
		r.chip_select_n = 1'b1;
		r.dio_out = 1'b1;
		// a start while idle launches the sequence on this very tick
		if (ph == PH_IDLE && tick.start_request) begin
			chan_latch = tick.channel;
			ph = PH_START_LOW;
			tick_div = '0;
			bits_in = 0;
			msb_word = '0;
			lsb_word = '0;
		end
		if (ph >= PH_START_LOW && ph <= PH_LSB_LOW) begin
			r.chip_select_n = 1'b0;
			r.serial_clock = ~ph[0];
			r.busy_res = 1'b1;
			case (ph)
				PH_MODE_LOW, PH_MODE_HIGH: r.dio_out = sel_mode;
				PH_CHAN_LOW, PH_CHAN_HIGH: r.dio_out = chan_latch;
				default: r.dio_out = 1'b1;
			endcase
			tick_div++;
			if (tick_div >= eff_half) begin
				tick_div = '0;
				case (ph)
					PH_MSB_LOW: begin
						msb_word = {msb_word[DBITS-2:0], tick.dio_in};
						bits_in++;
						// last msb-first bit doubles as the first lsb-first bit
						if (bits_in >= DBITS) begin
							lsb_word = '0;
							lsb_word[0] = tick.dio_in;
							bits_in = 0;
							ph = PH_LSB_HIGH;
						end else begin
							ph = PH_MSB_HIGH;
						end
					end
					PH_LSB_LOW: begin
						if (bits_in + 1 < DBITS)
							lsb_word[bits_in + 1] = tick.dio_in;
						bits_in++;
						ph = (bits_in >= DBITS) ? PH_DONE : PH_LSB_HIGH;
					end
					default: ph = phase_t'(ph + 1);
				endcase
			end
		end else if (ph == PH_DONE) begin
			r.done_res = 1'b1;
			r.readings_match = (msb_word == lsb_word);
			r.value = r.readings_match ? msb_word[VALUE_W-1:0] : '0;
			tick_div = '0;
			ph = PH_IDLE;
		end else begin
			ph = PH_IDLE;
		end
		return r;
	endfunction

	// level the converter puts on the data line for the coming tick
	function automatic logic converter_level();
		logic lvl;
		lvl = $urandom_range(1);
		if (ph == PH_MSB_LOW)
			lvl = adc_sample[DBITS - 1 - bits_in];
		else if (ph == PH_LSB_LOW && bits_in + 1 < DBITS)
			lvl = adc_sample[bits_in + 1] ^ lsb_flip[bits_in + 1];
		return lvl;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// one tick transfer on the input channel, with random idle cycles ahead of it
	task automatic send_tick(input logic start, input logic chan);
		in_item_t tick;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		tick.start_request = start;
		tick.channel = chan;
		tick.dio_in = noisy_line ? logic'($urandom_range(1)) : converter_level();
		in_ch.valid <= 1'b1;
		in_ch.start_request <= tick.start_request;
		in_ch.channel <= tick.channel;
		in_ch.dio_in <= tick.dio_in;
		do @(posedge clk); while (!in_ch.ready);
		pending_pins.push_back(pins_for_tick(tick));
		ticks_sent++;
	endtask

	// register write once the sequencer and the result path have gone quiet
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SINGLE_ENDED: sel_mode = data[0];
			CFG_HALF_PERIOD:  half_ticks = data;
			default: ;
		endcase
	endtask

	// full conversion: start tick, then ticks until the done tick has passed;
	// start and channel toggle at random while busy and must be ignored
	task automatic run_conversion(input logic chan, input logic [DBITS-1:0] sample,
		input logic [DBITS-1:0] flip, input logic noisy);
		adc_sample = sample;
		lsb_flip = flip;
		noisy_line = noisy;
		send_tick(1'b1, chan);
		while (ph != PH_IDLE)
			send_tick(logic'($urandom_range(1)), logic'($urandom_range(1)));
		noisy_line = 1'b0;
	endtask

	// idle pins with no start request
	task automatic test_idle_pins();
		repeat (6)
			send_tick(1'b0, logic'($urandom_range(1)));
	endtask

	// reset configuration first, then data extremes, a disagreeing read-back,
	// a noisy line and differential mode; conversions run back to back
	task automatic test_directed_reads();
		run_conversion(1'b0, 8'h5A, '0, 1'b0);
		write_reg(CFG_HALF_PERIOD, 8'd1);
		run_conversion(1'b0, 8'h00, '0, 1'b0);
		run_conversion(1'b1, 8'hFF, '0, 1'b0);
		run_conversion(1'b0, 8'h80, '0, 1'b0);
		run_conversion(1'b1, 8'h01, '0, 1'b0);
		run_conversion(1'b0, 8'hA5, 8'h10, 1'b0);
		run_conversion(1'b1, 8'h3C, '0, 1'b1);
		write_reg(CFG_SINGLE_ENDED, 8'd0);
		run_conversion(1'b0, 8'hC3, '0, 1'b0);
		run_conversion(1'b1, 8'h7E, '0, 1'b0);
		write_reg(CFG_SINGLE_ENDED, 8'd1);
	endtask

	// half period of zero behaves as one tick; the longest half period runs
	// past its first phase end, then the sequence finishes at one tick a phase
	task automatic test_period_extremes();
		write_reg(CFG_HALF_PERIOD, 8'd0);
		run_conversion(1'b1, 8'h96, '0, 1'b0);
		write_reg(CFG_HALF_PERIOD, 8'd255);
		adc_sample = 8'h69;
		lsb_flip = '0;
		noisy_line = 1'b0;
		send_tick(1'b1, 1'b0);
		repeat (259)
			send_tick(logic'($urandom_range(1)), logic'($urandom_range(1)));
		write_reg(CFG_HALF_PERIOD, 8'd1);
		while (ph != PH_IDLE)
			send_tick(logic'($urandom_range(1)), logic'($urandom_range(1)));
	endtask

	// random conversions under one idling pattern, reconfigured every few reads
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
		input int quota);
		int stop_at;
		int n;
		int k;
		logic [DBITS-1:0] sample;
		logic [DBITS-1:0] flip;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		stop_at = ticks_sent + quota;
		n = 0;
		while (ticks_sent < stop_at) begin
			if (n % 4 == 0) begin
				write_reg(CFG_SINGLE_ENDED, CFG_DATA_W'($urandom_range(1)));
				k = $urandom_range(99);
				write_reg(CFG_HALF_PERIOD, (k < 60) ? 8'd1 : (k < 85) ? 8'd2 :
					(k < 95) ? CFG_DATA_W'($urandom_range(3, 6)) : 8'd0);
			end
			repeat ($urandom_range(2))
				send_tick(1'b0, logic'($urandom_range(1)));
			k = $urandom_range(99);
			sample = (k < 5) ? '0 : (k < 10) ? '1 : DBITS'($urandom);
			flip = '0;
			// lsb-first bit zero is shared, so a flip there would change nothing
			if (k >= 85 && k < 95)
				flip = (DBITS'($urandom) | (DBITS'(1) << $urandom_range(1, DBITS - 1)))
					& ~DBITS'(1);
			run_conversion(logic'($urandom_range(1)), sample, flip, k >= 95);
			n++;
		end
	endtask

	// result checker: every result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_pins.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, out_ch.value);
				mismatches++;
			end else begin
				want_pins = pending_pins.pop_front();
				compare_field("chip_select_n", want_pins.chip_select_n, out_ch.chip_select_n);
				compare_field("serial_clock", want_pins.serial_clock, out_ch.serial_clock);
				compare_field("dio_out", want_pins.dio_out, out_ch.dio_out);
				compare_field("busy_res", want_pins.busy_res, out_ch.busy_res);
				compare_field("done_res", want_pins.done_res, out_ch.done_res);
				compare_field("value", want_pins.value, out_ch.value);
				compare_field("readings_match", want_pins.readings_match,
					out_ch.readings_match);
			end
		end
	end

	// receiver stalls at random, at the rate of the current phase
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SINGLE_ENDED;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.start_request = 1'b0;
		in_ch.channel = 1'b0;
		in_ch.dio_in = 1'b0;
		out_ch.ready = 1'b0;
		// shadow state as after reset
		sel_mode = MODE_RST;
		half_ticks = HALF_RST;
		ph = PH_IDLE;
		tick_div = '0;
		msb_word = '0;
		lsb_word = '0;
		bits_in = 0;
		chan_latch = 1'b0;
		adc_sample = '0;
		lsb_flip = '0;
		noisy_line = 1'b0;
		mismatches = 0;
		ticks_sent = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_pins();
		test_directed_reads();
		test_period_extremes();
		// idling patterns: none, sender idle, receiver stalling, both
		test_random_traffic(0, 0, 180);
		test_random_traffic(75, 0, 180);
		test_random_traffic(0, 75, 180);
		test_random_traffic(20, 20, 180);

		// drain, then let the two-stage result path settle
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_pins.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
